FILE: rtl/core/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, constants and helpers for the nearest palette colour match.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

	// default number of palette entries
	localparam int PALETTE_DEPTH_DEF = 16;

	// field widths
	localparam int ENTRY_IDX_W = 4;
	localparam int RGB15_W     = 15;
	localparam int ARGB_W      = 32;
	localparam int COLOR_IDX_W = 4;
	localparam int CHAN_W      = 8;
	localparam int ENTRY_W     = 3 * CHAN_W;
	localparam int DIST_W      = CHAN_W + 2;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int THRESH_W   = 9;
	localparam int PSIZE_W    = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_THRESHOLD = 1'd0,
		CFG_PALETTE_SIZE    = 1'd1
	} cfg_idx_t;

	localparam logic [THRESH_W-1:0] THRESH_RST = 9'd128;
	localparam logic [PSIZE_W-1:0]  PSIZE_RST  = 5'd16;

	// item function codes
	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_PIXEL = 1'b1
	} func_t;

	// opaque magenta is always mapped to the transparent slot
	localparam logic [ARGB_W-1:0] MAGENTA_ARGB = 32'hFFFF_00FF;
	localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;

	// 5-bit to 8-bit channel widening, round to nearest of c*255/31
	localparam logic [CHAN_W-1:0] WIDEN5_LUT [32] = '{
		8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
		8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
		8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
		8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
	};

	function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] c);
		return WIDEN5_LUT[c];
	endfunction

	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
	                                              input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/npcm_in_if.sv
// ----------------------------------------------------------------------------
// npcm_in_if
// Input channel: palette loads and pixels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface npcm_in_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic [npcm_pkg::ENTRY_IDX_W-1:0]   entry_index;
	logic [npcm_pkg::RGB15_W-1:0]       entry_rgb15;
	logic [npcm_pkg::ARGB_W-1:0]        pixel_argb;

	modport source (output valid, func, entry_index, entry_rgb15, pixel_argb, input ready);
	modport sink   (input valid, func, entry_index, entry_rgb15, pixel_argb, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/npcm_out_if.sv
// ----------------------------------------------------------------------------
// npcm_out_if
// Output channel: chosen palette index, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface npcm_out_if;
	logic                               valid;
	logic                               ready;
	logic [npcm_pkg::COLOR_IDX_W-1:0]   color_index;

	modport source (output valid, color_index, input ready);
	modport sink   (input valid, color_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nearest_palette_color_match.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Maps ARGB pixels to the palette entry, index 1 up, with least L1 distance; loads
// BGR555 palette entries widened to 8 bits per channel.
// ----------------------------------------------------------------------------
// Load beat: written at the accepting edge, no result; ready stays high after it.
// Pixel beat: transparent or magenta pixels and sizes of one or less skip the scan;
// otherwise entries 1 to n-1 are read and compared in order (n = entries in use).
// Idle, and so ready, comes back as the result registers; a stalled result waits in hold.
// Reset clears control, threshold to 128, size to 16; palette contents undefined.
`default_nettype none

module nearest_palette_color_match #(
	parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_write_en,
	input  wire  [npcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [npcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	npcm_in_if.sink                             pixel_in,
	npcm_out_if.source                          index_out
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = $clog2(PALETTE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DONE = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                                 state_q;
	logic [npcm_pkg::THRESH_W-1:0]          thresh_q;
	logic [npcm_pkg::PSIZE_W-1:0]           psize_q;
	logic [npcm_pkg::ENTRY_W-1:0]           store [PALETTE_DEPTH];
	logic [npcm_pkg::ENTRY_W-1:0]           rd_data_q;
	logic [CW-1:0]                          rd_cnt_q;
	logic                                   pend_q;
	logic [AW-1:0]                          pend_idx_q;
	logic                                   have_q;
	logic [AW-1:0]                          best_q;
	logic [npcm_pkg::DIST_W-1:0]            best_dist_q;
	logic [npcm_pkg::ARGB_W-1:0]            px_q;
	logic                                   out_valid_q;
	logic [npcm_pkg::COLOR_IDX_W-1:0]       out_index_q;

	logic                                   in_fire;
	logic                                   load_fire;
	logic                                   pixel_fire;
	logic [CW-1:0]                          n_used;
	logic                                   early_zero;
	logic                                   can_load;
	logic [npcm_pkg::DIST_W-1:0]            l1_sum;
	logic [npcm_pkg::ENTRY_W-1:0]           wr_entry;

	// handshake
	assign pixel_in.ready = (state_q == ST_IDLE);
	assign in_fire        = pixel_in.valid && pixel_in.ready;
	assign load_fire      = in_fire && (pixel_in.func == npcm_pkg::FUNC_LOAD);
	assign pixel_fire     = in_fire && (pixel_in.func == npcm_pkg::FUNC_PIXEL);
	assign can_load       = !out_valid_q || index_out.ready;

	// entries in use, saturated to the store depth
	assign n_used = (32'(psize_q) > PALETTE_DEPTH) ? CW'(PALETTE_DEPTH) : CW'(psize_q);

	// pixels that map straight to the transparent slot
	assign early_zero = ({1'b0, pixel_in.pixel_argb[31:24]} < thresh_q)
		|| (pixel_in.pixel_argb == npcm_pkg::MAGENTA_ARGB)
		|| (n_used <= CW'(1));

	// widened palette colour, red high
	assign wr_entry = {npcm_pkg::widen5(pixel_in.entry_rgb15[4:0]),
	                   npcm_pkg::widen5(pixel_in.entry_rgb15[9:5]),
	                   npcm_pkg::widen5(pixel_in.entry_rgb15[14:10])};

	// shared distance unit: L1 over R, G, B and alpha (entries are opaque)
	assign l1_sum = npcm_pkg::DIST_W'(npcm_pkg::absdiff(px_q[23:16], rd_data_q[23:16]))
		+ npcm_pkg::DIST_W'(npcm_pkg::absdiff(px_q[15:8], rd_data_q[15:8]))
		+ npcm_pkg::DIST_W'(npcm_pkg::absdiff(px_q[7:0], rd_data_q[7:0]))
		+ npcm_pkg::DIST_W'(npcm_pkg::CHAN_MAX - px_q[31:24]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= npcm_pkg::THRESH_RST;
			psize_q  <= npcm_pkg::PSIZE_RST;
		end else if (cfg_write_en) begin
			unique case (npcm_pkg::cfg_idx_t'(cfg_index))
				npcm_pkg::CFG_ALPHA_THRESHOLD: thresh_q <= cfg_data;
				npcm_pkg::CFG_PALETTE_SIZE:    psize_q  <= cfg_data[npcm_pkg::PSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// palette store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (load_fire && (32'(pixel_in.entry_index) < PALETTE_DEPTH)) begin
			store[AW'(pixel_in.entry_index)] <= wr_entry;
		end
		rd_data_q <= store[rd_cnt_q[AW-1:0]];
	end

	// pixel latch
	always_ff @(posedge clk) begin
		if (pixel_fire) begin
			px_q <= pixel_in.pixel_argb;
		end
	end

	// sequencer and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			pend_q      <= 1'b0;
			pend_idx_q  <= '0;
			have_q      <= 1'b0;
			best_q      <= '0;
			best_dist_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pixel_fire) begin
						have_q   <= 1'b0;
						best_q   <= '0;
						pend_q   <= 1'b0;
						rd_cnt_q <= CW'(1);
						state_q  <= early_zero ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue the next read
					if (rd_cnt_q < n_used) begin
						pend_q     <= 1'b1;
						pend_idx_q <= rd_cnt_q[AW-1:0];
						rd_cnt_q   <= rd_cnt_q + CW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_DONE;
						end
					end
					// compare the entry read last cycle, lower index wins ties
					if (pend_q && (!have_q || l1_sum < best_dist_q)) begin
						have_q      <= 1'b1;
						best_dist_q <= l1_sum;
						best_q      <= pend_idx_q;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE || state_q == ST_HOLD) && can_load) begin
			out_valid_q <= 1'b1;
		end else if (index_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE || state_q == ST_HOLD) && can_load) begin
			out_index_q <= npcm_pkg::COLOR_IDX_W'(best_q);
		end
	end

	assign index_out.valid       = out_valid_q;
	assign index_out.color_index = out_index_q;

	// a pixel beat always leaves idle
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_fire |=> (state_q != ST_IDLE))
		else $error("pixel beat accepted but sequencer stayed idle");

	// scan never reads past the entries in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= n_used))
		else $error("scan counter beyond palette size");

	// a pending compare only exists while scanning
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_SCAN))
		else $error("pending compare outside scan");

	// chosen index is zero or inside the searched range
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> ((best_q == '0) || (CW'(best_q) < n_used)))
		else $error("best index outside palette");

	// a result leaves done or hold only once it has been registered
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE || state_q == ST_HOLD) && can_load) |=> out_valid_q)
		else $error("result lost on its way to the output register");

endmodule

`default_nettype wire
